// File: hdl/hufp_pkg.sv
// hufp_pkg: shared constants, type codes and controller/datapath interface structs
// for the hid uart frame parser; used by every module of the block but hufp_ram
`default_nettype none

package hufp_pkg;

    // default sizes
    localparam int RX_BUFFER_BYTES_DEF = 64;
    localparam int KEY_DATA_MAX_DEF    = 32;

    // frame bytes
    localparam logic [7:0] HDR_BYTE0    = 8'h57;
    localparam logic [7:0] HDR_BYTE1    = 8'hAB;
    localparam logic [7:0] T_STAT_REQ   = 8'h82;
    localparam logic [7:0] T_KEY_A      = 8'h83;
    localparam logic [7:0] T_KEY_B      = 8'h88;
    localparam logic [7:0] T_RESET      = 8'h84;
    localparam logic [7:0] T_STAT1      = 8'h85;
    localparam logic [7:0] T_DISCONNECT = 8'h86;
    localparam logic [7:0] T_VERSION    = 8'h87;
    localparam logic [7:0] T_STAT2      = 8'h40;
    localparam logic [7:0] T_STAT       = 8'h80;
    localparam logic [7:0] STAT_REQ_MASK = 8'hA0;

    // event codes
    localparam logic [2:0] EV_OK       = 3'd0;
    localparam logic [2:0] EV_OVERFLOW = 3'd1;
    localparam logic [2:0] EV_LEN      = 3'd2;
    localparam logic [2:0] EV_KEY_LEN  = 3'd3;
    localparam logic [2:0] EV_CHECKSUM = 3'd4;

    // message type codes
    localparam logic [2:0] MT_STAT_REQ   = 3'd0;
    localparam logic [2:0] MT_KEY        = 3'd1;
    localparam logic [2:0] MT_RESET      = 3'd2;
    localparam logic [2:0] MT_STAT1      = 3'd3;
    localparam logic [2:0] MT_DISCONNECT = 3'd4;
    localparam logic [2:0] MT_VERSION    = 3'd5;
    localparam logic [2:0] MT_STAT2      = 3'd6;
    localparam logic [2:0] MT_STAT       = 3'd7;

    // how a type byte is handled
    typedef enum logic [2:0] {
        CLS_STAT_REQ,
        CLS_KEY,
        CLS_NOARG,
        CLS_ARG,
        CLS_BAD
    } cls_t;

    // which result goes into the output register
    typedef enum logic [2:0] {
        RES_OVF,
        RES_LEN,
        RES_KVL,
        RES_SUM,
        RES_FRAME,
        RES_KEYDATA
    } res_t;

    typedef struct packed {
        logic accept;
        logic drop;
        logic flush;
        logic off_clr;
        logic off_inc;
        logic walk_start;
        logic emit_start;
        logic cap_hdr;
        logic cap_key;
        logic load;
        res_t res;
    } cmd_t;

    typedef struct packed {
        logic full;
        logic cnt_lt3;
        logic cnt_lt4;
        logic hdr_ok;
        cls_t cls;
        logic stat_req_ok;
        logic key_short;
        logic len_over;
        logic kv_over;
        logic hdr_last;
        logic walk_done;
        logic sum_ok;
        logic kv_zero;
        logic emit_last;
        logic out_free;
    } sts_t;

    function automatic cls_t type_class(logic [7:0] t);
        cls_t c;
        case (t)
            T_STAT_REQ:                      c = CLS_STAT_REQ;
            T_KEY_A, T_KEY_B:                c = CLS_KEY;
            T_RESET, T_DISCONNECT, T_VERSION: c = CLS_NOARG;
            T_STAT1, T_STAT2, T_STAT:        c = CLS_ARG;
            default:                         c = CLS_BAD;
        endcase
        return c;
    endfunction

    function automatic logic [2:0] type_code(logic [7:0] t);
        logic [2:0] m;
        case (t)
            T_STAT_REQ:       m = MT_STAT_REQ;
            T_KEY_A, T_KEY_B: m = MT_KEY;
            T_RESET:          m = MT_RESET;
            T_STAT1:          m = MT_STAT1;
            T_DISCONNECT:     m = MT_DISCONNECT;
            T_VERSION:        m = MT_VERSION;
            T_STAT2:          m = MT_STAT2;
            T_STAT:           m = MT_STAT;
            default:          m = MT_STAT_REQ;
        endcase
        return m;
    endfunction

endpackage

`default_nettype wire

// File: hdl/hufp_ram.sv
// hufp_ram: generic single-write, single-read ram with registered read data
// no dependencies
`default_nettype none

module hufp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// File: hdl/hufp_datapath.sv
// hufp_datapath: circular frame buffer, header/key byte registers, checksum
// accumulator and output register; uses hufp_pkg and hufp_ram
`default_nettype none

module hufp_datapath #(
    parameter int BUF_BYTES = hufp_pkg::RX_BUFFER_BYTES_DEF,
    parameter int KEY_MAX   = hufp_pkg::KEY_DATA_MAX_DEF
) (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic [7:0]      rx_byte,
    input  wire hufp_pkg::cmd_t  cmd,
    output hufp_pkg::sts_t       sts,
    input  wire logic            res_ready,
    output logic                 res_valid,
    output logic [2:0]           event_res,
    output logic [2:0]           msg_type,
    output logic [7:0]           status_byte,
    output logic                 port,
    output logic [1:0]           protocol,
    output logic [1:0]           kind,
    output logic [7:0]           serial_number,
    output logic [7:0]           check_byte,
    output logic [7:0]           data_byte,
    output logic [5:0]           data_count,
    output logic                 last
);

    import hufp_pkg::*;

    localparam int IDX_W = $clog2(BUF_BYTES);
    localparam int CNT_W = $clog2(BUF_BYTES + 1);
    localparam int CMP_W = 10;
    localparam logic [CNT_W-1:0] BUF_N   = CNT_W'(BUF_BYTES);
    localparam logic [CMP_W-1:0] LEN_MAX = CMP_W'(BUF_BYTES - 4);
    localparam logic [7:0]       KV_MAX  = 8'(KEY_MAX);

    function automatic logic [IDX_W-1:0] wrap_add(logic [IDX_W-1:0] a, logic [IDX_W-1:0] b);
        logic [IDX_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        if (s >= (IDX_W+1)'(BUF_BYTES))
        begin
            s = s - (IDX_W+1)'(BUF_BYTES);
        end
        return s[IDX_W-1:0];
    endfunction

    logic [CNT_W-1:0] count_reg, count_next;
    logic [IDX_W-1:0] head_reg, head_next;
    logic [IDX_W-1:0] off_reg, off_next;
    logic [7:0]       b0_reg, b1_reg, b2_reg, b3_reg;
    logic [7:0]       label_reg, serial_reg, check_reg, sum_reg;
    logic             out_valid_reg;
    logic [2:0]       ev_reg, mt_reg;
    logic [7:0]       st_reg, ser_out_reg, chk_out_reg, data_reg, lab_out_reg;
    logic [5:0]       cnt_out_reg;
    logic             last_reg;

    logic             we;
    logic [IDX_W-1:0] waddr, raddr;
    logic [7:0]       rd_data;
    logic             full;
    logic [7:0]       kv;
    logic [CMP_W-1:0] cnt_ext, off_ext, kv_ext, len_ext;
    cls_t             cls;

    hufp_ram #(
        .WIDTH(8),
        .DEPTH(BUF_BYTES)
    ) u_buf (
        .clk  (clk),
        .we   (we),
        .waddr(waddr),
        .wdata(rx_byte),
        .raddr(raddr),
        .rdata(rd_data)
    );

    assign full    = (count_reg >= BUF_N);
    assign we      = cmd.accept;
    assign waddr   = full ? '0 : wrap_add(head_reg, count_reg[IDX_W-1:0]);
    assign raddr   = wrap_add(head_reg, off_reg);
    assign kv      = b3_reg - 8'd3;
    assign cnt_ext = CMP_W'(count_reg);
    assign off_ext = CMP_W'(off_reg);
    assign kv_ext  = CMP_W'(kv);
    assign len_ext = CMP_W'(b3_reg);
    assign cls     = type_class(b2_reg);

    always_comb
    begin
        sts.full        = full;
        sts.cnt_lt3     = (cnt_ext < CMP_W'(3));
        sts.cnt_lt4     = (cnt_ext < CMP_W'(4));
        sts.hdr_ok      = (b0_reg == HDR_BYTE0) && (b1_reg == HDR_BYTE1);
        sts.cls         = cls;
        sts.stat_req_ok = ((b3_reg & STAT_REQ_MASK) == STAT_REQ_MASK);
        sts.key_short   = (cnt_ext < len_ext + CMP_W'(4));
        sts.len_over    = (len_ext > LEN_MAX);
        sts.kv_over     = (kv > KV_MAX);
        sts.hdr_last    = (off_reg == IDX_W'(3));
        sts.walk_done   = (off_ext == kv_ext + CMP_W'(6));
        sts.sum_ok      = (sum_reg == check_reg);
        sts.kv_zero     = (kv == 8'd0);
        sts.emit_last   = (off_ext == kv_ext + CMP_W'(4));
        sts.out_free    = !out_valid_reg || res_ready;
    end

    // buffer pointers and read offset
    always_comb
    begin
        count_next = count_reg;
        head_next  = head_reg;
        off_next   = off_reg;
        if (cmd.accept)
        begin
            if (full)
            begin
                head_next  = '0;
                count_next = CNT_W'(1);
            end
            else
            begin
                count_next = count_reg + CNT_W'(1);
            end
        end
        else if (cmd.drop)
        begin
            head_next  = wrap_add(head_reg, IDX_W'(1));
            count_next = count_reg - CNT_W'(1);
        end
        else if (cmd.flush)
        begin
            head_next  = '0;
            count_next = '0;
        end
        if (cmd.off_clr)
        begin
            off_next = '0;
        end
        else if (cmd.walk_start)
        begin
            off_next = IDX_W'(4);
        end
        else if (cmd.emit_start)
        begin
            off_next = IDX_W'(5);
        end
        else if (cmd.off_inc)
        begin
            off_next = off_reg + IDX_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            head_reg      <= '0;
            off_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            head_reg  <= head_next;
            off_reg   <= off_next;
            if (cmd.load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (res_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // captured frame bytes and checksum
    always_ff @(posedge clk)
    begin
        if (cmd.cap_hdr)
        begin
            case (off_reg[1:0])
                2'd0:    b0_reg <= rd_data;
                2'd1:    b1_reg <= rd_data;
                2'd2:    b2_reg <= rd_data;
                default: b3_reg <= rd_data;
            endcase
        end
        if (cmd.walk_start)
        begin
            sum_reg <= 8'd0;
        end
        if (cmd.cap_key)
        begin
            if (off_ext == CMP_W'(4))
            begin
                label_reg <= rd_data;
            end
            if (off_ext >= CMP_W'(5) && off_ext <= kv_ext + CMP_W'(5))
            begin
                sum_reg <= sum_reg + rd_data;
            end
            if (off_ext == kv_ext + CMP_W'(5))
            begin
                serial_reg <= rd_data;
            end
            if (off_ext == kv_ext + CMP_W'(6))
            begin
                check_reg <= rd_data;
            end
        end
    end

    // output register
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            ev_reg      <= EV_OK;
            mt_reg      <= MT_KEY;
            st_reg      <= 8'd0;
            lab_out_reg <= 8'd0;
            ser_out_reg <= 8'd0;
            chk_out_reg <= 8'd0;
            data_reg    <= 8'd0;
            cnt_out_reg <= 6'd0;
            last_reg    <= 1'b1;
            case (cmd.res)
                RES_OVF:
                begin
                    ev_reg <= EV_OVERFLOW;
                    mt_reg <= MT_STAT_REQ;
                end
                RES_LEN: ev_reg <= EV_LEN;
                RES_KVL: ev_reg <= EV_KEY_LEN;
                RES_SUM: ev_reg <= EV_CHECKSUM;
                RES_FRAME:
                begin
                    mt_reg <= type_code(b2_reg);
                    if (cls == CLS_STAT_REQ)
                    begin
                        st_reg <= {4'd0, b3_reg[3:0]};
                    end
                    else if (cls == CLS_ARG)
                    begin
                        st_reg <= b3_reg;
                    end
                    if (cls == CLS_KEY)
                    begin
                        lab_out_reg <= label_reg;
                        ser_out_reg <= serial_reg;
                        chk_out_reg <= check_reg;
                    end
                end
                RES_KEYDATA:
                begin
                    lab_out_reg <= label_reg;
                    ser_out_reg <= serial_reg;
                    chk_out_reg <= check_reg;
                    data_reg    <= rd_data;
                    cnt_out_reg <= kv[5:0];
                    last_reg    <= sts.emit_last;
                end
                default: ev_reg <= EV_OK;
            endcase
        end
    end

    assign res_valid     = out_valid_reg;
    assign event_res     = ev_reg;
    assign msg_type      = mt_reg;
    assign status_byte   = st_reg;
    assign port          = lab_out_reg[0];
    assign protocol      = lab_out_reg[2:1];
    assign kind          = lab_out_reg[5:4];
    assign serial_number = ser_out_reg;
    assign check_byte    = chk_out_reg;
    assign data_byte     = data_reg;
    assign data_count    = cnt_out_reg;
    assign last          = last_reg;

endmodule

`default_nettype wire

// File: hdl/hufp_ctrl.sv
// hufp_ctrl: frame decode sequencer driving the datapath by command struct
// uses hufp_pkg
`default_nettype none

module hufp_ctrl (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           rx_valid,
    output logic                rx_ready,
    input  wire hufp_pkg::sts_t sts,
    output hufp_pkg::cmd_t      cmd
);

    import hufp_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE,
        S_HDRA,
        S_HDRB,
        S_DEC,
        S_KA,
        S_KB,
        S_CMP,
        S_EMA,
        S_EMB,
        S_ONE
    } state_t;

    state_t state_reg, state_next;
    res_t   res_reg, res_next;

    always_comb
    begin
        state_next = state_reg;
        res_next   = res_reg;
        cmd        = '0;
        cmd.res    = res_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (rx_valid)
                begin
                    cmd.accept = 1'b1;
                    if (sts.full)
                    begin
                        res_next   = RES_OVF;
                        state_next = S_ONE;
                    end
                    else
                    begin
                        cmd.off_clr = 1'b1;
                        state_next  = S_HDRA;
                    end
                end
            end
            S_HDRA:
            begin
                if (sts.cnt_lt3)
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    state_next = S_HDRB;
                end
            end
            S_HDRB:
            begin
                cmd.cap_hdr = 1'b1;
                if (sts.hdr_last)
                begin
                    state_next = S_DEC;
                end
                else
                begin
                    cmd.off_inc = 1'b1;
                    state_next  = S_HDRA;
                end
            end
            S_DEC:
            begin
                if (!sts.hdr_ok)
                begin
                    cmd.drop    = 1'b1;
                    cmd.off_clr = 1'b1;
                    state_next  = S_HDRA;
                end
                else
                begin
                    case (sts.cls)
                        CLS_STAT_REQ:
                        begin
                            if (sts.cnt_lt4)
                            begin
                                state_next = S_IDLE;
                            end
                            else if (!sts.stat_req_ok)
                            begin
                                cmd.drop    = 1'b1;
                                cmd.off_clr = 1'b1;
                                state_next  = S_HDRA;
                            end
                            else
                            begin
                                res_next   = RES_FRAME;
                                state_next = S_ONE;
                            end
                        end
                        CLS_KEY:
                        begin
                            if (sts.cnt_lt4 || sts.key_short)
                            begin
                                state_next = S_IDLE;
                            end
                            else if (sts.len_over)
                            begin
                                res_next   = RES_LEN;
                                state_next = S_ONE;
                            end
                            else if (sts.kv_over)
                            begin
                                res_next   = RES_KVL;
                                state_next = S_ONE;
                            end
                            else
                            begin
                                cmd.walk_start = 1'b1;
                                state_next     = S_KA;
                            end
                        end
                        CLS_NOARG:
                        begin
                            res_next   = RES_FRAME;
                            state_next = S_ONE;
                        end
                        CLS_ARG:
                        begin
                            if (sts.cnt_lt4)
                            begin
                                state_next = S_IDLE;
                            end
                            else
                            begin
                                res_next   = RES_FRAME;
                                state_next = S_ONE;
                            end
                        end
                        default:
                        begin
                            cmd.drop    = 1'b1;
                            cmd.off_clr = 1'b1;
                            state_next  = S_HDRA;
                        end
                    endcase
                end
            end
            S_KA:
            begin
                state_next = S_KB;
            end
            S_KB:
            begin
                cmd.cap_key = 1'b1;
                if (sts.walk_done)
                begin
                    state_next = S_CMP;
                end
                else
                begin
                    cmd.off_inc = 1'b1;
                    state_next  = S_KA;
                end
            end
            S_CMP:
            begin
                if (!sts.sum_ok)
                begin
                    res_next   = RES_SUM;
                    state_next = S_ONE;
                end
                else if (sts.kv_zero)
                begin
                    res_next   = RES_FRAME;
                    state_next = S_ONE;
                end
                else
                begin
                    cmd.emit_start = 1'b1;
                    state_next     = S_EMA;
                end
            end
            S_EMA:
            begin
                state_next = S_EMB;
            end
            S_EMB:
            begin
                if (sts.out_free)
                begin
                    cmd.load = 1'b1;
                    cmd.res  = RES_KEYDATA;
                    if (sts.emit_last)
                    begin
                        cmd.flush  = 1'b1;
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        cmd.off_inc = 1'b1;
                        state_next  = S_EMA;
                    end
                end
            end
            S_ONE:
            begin
                if (sts.out_free)
                begin
                    cmd.load   = 1'b1;
                    cmd.flush  = (res_reg != RES_OVF);
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            res_reg   <= RES_OVF;
        end
        else
        begin
            state_reg <= state_next;
            res_reg   <= res_next;
        end
    end

    assign rx_ready = (state_reg == S_IDLE);

endmodule

`default_nettype wire

// File: hdl/hid_uart_frame_parser.sv
// hid_uart_frame_parser: a word is taken only while the sequencer idles; a decode pass
// then reads each header byte from the buffer and makes the type decision, rereads
// the header after each dropped head byte and goes back to idle with fewer than 3
// bytes buffered; a key frame adds a checksum walk and one word per key-data byte
// reset clears the fill count, head pointer, sequencer state and output valid; buffer
// contents stay undefined and need no clearing pass
`default_nettype none

module hid_uart_frame_parser #(
    parameter int RX_BUFFER_BYTES = hufp_pkg::RX_BUFFER_BYTES_DEF,
    parameter int KEY_DATA_MAX    = hufp_pkg::KEY_DATA_MAX_DEF
) (
    input  wire logic       clk,
    input  wire logic       rst_n,
    // received byte channel
    input  wire logic       rx_valid,
    output logic            rx_ready,
    input  wire logic [7:0] rx_byte,
    // result channel
    output logic            res_valid,
    input  wire logic       res_ready,
    output logic [2:0]      event_res,
    output logic [2:0]      msg_type,
    output logic [7:0]      status_byte,
    output logic            port,
    output logic [1:0]      protocol,
    output logic [1:0]      kind,
    output logic [7:0]      serial_number,
    output logic [7:0]      check_byte,
    output logic [7:0]      data_byte,
    output logic [5:0]      data_count,
    output logic            last
);

    import hufp_pkg::*;

    // command and status between sequencer and datapath
    cmd_t cmd;
    sts_t sts;

    // sequencer: accepts a word only when idle, then walks the decode steps
    // (header fetch, type decision, checksum walk, key-data emission)
    hufp_ctrl u_ctrl (
        .clk     (clk),
        .rst_n   (rst_n),
        .rx_valid(rx_valid),
        .rx_ready(rx_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    // datapath: circular buffer so a dropped head byte is a pointer bump,
    // output register lets a finished result wait while the next word comes in
    hufp_datapath #(
        .BUF_BYTES(RX_BUFFER_BYTES),
        .KEY_MAX  (KEY_DATA_MAX)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .rx_byte      (rx_byte),
        .cmd          (cmd),
        .sts          (sts),
        .res_ready    (res_ready),
        .res_valid    (res_valid),
        .event_res    (event_res),
        .msg_type     (msg_type),
        .status_byte  (status_byte),
        .port         (port),
        .protocol     (protocol),
        .kind         (kind),
        .serial_number(serial_number),
        .check_byte   (check_byte),
        .data_byte    (data_byte),
        .data_count   (data_count),
        .last         (last)
    );

endmodule

`default_nettype wire

// File: tb/testbench.sv
// self-checking testbench for hid_uart_frame_parser: feeds received bytes over valid/ready,
// decodes them with its own frame model and checks every result word in order
// depends on hufp_pkg (hdl/hufp_pkg.sv) and the block in hdl/hid_uart_frame_parser.sv
module testbench;
    import hufp_pkg::*;

    localparam int BUF_BYTES    = RX_BUFFER_BYTES_DEF;
    localparam int KEY_MAX      = KEY_DATA_MAX_DEF;
    localparam int LIMIT_CYCLES = 5000000;
    // worst decode: a full buffer of dropped head bytes plus a key walk
    localparam int SETTLE_CYCLES = 2000;
    localparam int PHASE_BYTES   = 117;

    // who idles while a stretch of bytes goes through
    typedef enum int {
        SLOW_READER,
        SLOW_WRITER,
        NO_IDLE
    } idle_mode_t;

    typedef struct packed {
        logic [2:0] event_res;
        logic [2:0] msg_type;
        logic [7:0] status_byte;
        logic       port;
        logic [1:0] protocol;
        logic [1:0] kind;
        logic [7:0] serial_number;
        logic [7:0] check_byte;
        logic [7:0] data_byte;
        logic [5:0] data_count;
        logic       last;
    } hid_result_t;

    // one planned byte; hold_for_drain keeps it back until every result has come
    typedef struct {
        logic [7:0] value;
        idle_mode_t mode;
        bit         hold_for_drain;
    } rx_plan_t;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       rx_valid = 1'b0;
    logic       rx_ready;
    logic [7:0] rx_byte = 8'h00;
    logic       res_valid;
    logic       res_ready = 1'b0;
    logic [2:0] event_res;
    logic [2:0] msg_type;
    logic [7:0] status_byte;
    logic       port;
    logic [1:0] protocol;
    logic [1:0] kind;
    logic [7:0] serial_number;
    logic [7:0] check_byte;
    logic [7:0] data_byte;
    logic [5:0] data_count;
    logic       last;

    hid_uart_frame_parser dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .rx_valid      (rx_valid),
        .rx_ready      (rx_ready),
        .rx_byte       (rx_byte),
        .res_valid     (res_valid),
        .res_ready     (res_ready),
        .event_res     (event_res),
        .msg_type      (msg_type),
        .status_byte   (status_byte),
        .port          (port),
        .protocol      (protocol),
        .kind          (kind),
        .serial_number (serial_number),
        .check_byte    (check_byte),
        .data_byte     (data_byte),
        .data_count    (data_count),
        .last          (last)
    );

    // 12 unit period
    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // frame decoder model: its own copy of the frame buffer and fill count
    // ------------------------------------------------------------------
    logic [7:0]  frame_buf [BUF_BYTES];
    int          frame_fill = 0;
    hid_result_t pending_results [$];

    function automatic hid_result_t single_result(logic [2:0] ev, logic [2:0] mt);
        hid_result_t r;
        r = '0;
        r.event_res = ev;
        r.msg_type  = mt;
        r.last      = 1'b1;
        return r;
    endfunction

    // resync: shift out the oldest buffered byte
    task automatic drop_head_byte();
        int i;
        for (i = 0; i + 1 < frame_fill; i++)
            frame_buf[i] = frame_buf[i + 1];
        if (frame_fill > 0)
            frame_fill--;
    endtask

    // append one received byte and queue whatever results it completes
    task automatic decode_rx_byte(input logic [7:0] b);
        hid_result_t r;
        logic [7:0]  t;
        logic [7:0]  b3;
        logic [7:0]  sum;
        int          len;
        int          kv;
        int          i;
        bit          retry;
        // a full buffer is flushed before the new byte goes in
        if (frame_fill >= BUF_BYTES)
        begin
            frame_buf[0] = b;
            frame_fill   = 1;
            pending_results.push_back(single_result(EV_OVERFLOW, MT_STAT_REQ));
            return;
        end
        frame_buf[frame_fill] = b;
        frame_fill++;
        retry = 1'b1;
        while (retry && frame_fill >= 3)
        begin
            retry = 1'b0;
            if (frame_buf[0] != HDR_BYTE0 || frame_buf[1] != HDR_BYTE1)
            begin
                drop_head_byte();
                retry = 1'b1;
            end
            else
            begin
                t  = frame_buf[2];
                b3 = (frame_fill >= 4) ? frame_buf[3] : 8'h00;
                case (t)
                    T_STAT_REQ:
                    begin
                        if (frame_fill >= 4)
                        begin
                            // status request needs both mask bits, else it is noise
                            if ((b3 & STAT_REQ_MASK) != STAT_REQ_MASK)
                            begin
                                drop_head_byte();
                                retry = 1'b1;
                            end
                            else
                            begin
                                r = single_result(EV_OK, MT_STAT_REQ);
                                r.status_byte = {4'h0, b3[3:0]};
                                pending_results.push_back(r);
                                frame_fill = 0;
                            end
                        end
                    end
                    T_KEY_A, T_KEY_B:
                    begin
                        len = b3;
                        if (frame_fill >= 4 && frame_fill >= len + 4)
                        begin
                            // key data length wraps in 8 bits for short lengths
                            kv = (len - 3) & 8'hFF;
                            frame_fill = 0;
                            if (len > BUF_BYTES - 4)
                                pending_results.push_back(single_result(EV_LEN, MT_KEY));
                            else if (kv > KEY_MAX)
                                pending_results.push_back(single_result(EV_KEY_LEN, MT_KEY));
                            else
                            begin
                                sum = frame_buf[5 + kv];
                                for (i = 0; i < kv; i++)
                                    sum += frame_buf[5 + i];
                                if (sum != frame_buf[6 + kv])
                                    pending_results.push_back(single_result(EV_CHECKSUM, MT_KEY));
                                else
                                begin
                                    r = single_result(EV_OK, MT_KEY);
                                    r.port          = frame_buf[4][0];
                                    r.protocol      = frame_buf[4][2:1];
                                    r.kind          = frame_buf[4][5:4];
                                    r.serial_number = frame_buf[5 + kv];
                                    r.check_byte    = frame_buf[6 + kv];
                                    if (kv == 0)
                                        pending_results.push_back(r);
                                    // one word per key-data byte, last flags the final one
                                    for (i = 0; i < kv; i++)
                                    begin
                                        r.data_byte  = frame_buf[5 + i];
                                        r.data_count = 6'(kv);
                                        r.last       = (i == kv - 1);
                                        pending_results.push_back(r);
                                    end
                                end
                            end
                        end
                    end
                    T_RESET:
                    begin
                        pending_results.push_back(single_result(EV_OK, MT_RESET));
                        frame_fill = 0;
                    end
                    T_DISCONNECT:
                    begin
                        pending_results.push_back(single_result(EV_OK, MT_DISCONNECT));
                        frame_fill = 0;
                    end
                    T_VERSION:
                    begin
                        pending_results.push_back(single_result(EV_OK, MT_VERSION));
                        frame_fill = 0;
                    end
                    T_STAT1, T_STAT2, T_STAT:
                    begin
                        if (frame_fill >= 4)
                        begin
                            r = single_result(EV_OK, (t == T_STAT1) ? MT_STAT1 :
                                                     (t == T_STAT2) ? MT_STAT2 : MT_STAT);
                            r.status_byte = b3;
                            pending_results.push_back(r);
                            frame_fill = 0;
                        end
                    end
                    default:
                    begin
                        // unknown type byte: resync one byte further on
                        drop_head_byte();
                        retry = 1'b1;
                    end
                endcase
            end
        end
    endtask

    // ------------------------------------------------------------------
    // byte plan: filled once at time zero, consumed by the driver
    // ------------------------------------------------------------------
    rx_plan_t   rx_plan [$];
    idle_mode_t plan_mode = SLOW_READER;
    bit         plan_hold = 1'b0;

    task automatic plan_byte(input logic [7:0] v);
        rx_plan.push_back('{v, plan_mode, plan_hold});
        plan_hold = 1'b0;
    endtask

    // well-formed key frame with kv data bytes; corrupt flips one checksum bit
    task automatic plan_key_frame(input int kv, input bit corrupt);
        logic [7:0] serial;
        logic [7:0] sum;
        logic [7:0] v;
        int         i;
        serial = 8'($urandom);
        plan_byte(HDR_BYTE0);
        plan_byte(HDR_BYTE1);
        plan_byte($urandom_range(1) ? T_KEY_A : T_KEY_B);
        plan_byte(8'(kv + 3));
        plan_byte(8'($urandom));
        sum = serial;
        for (i = 0; i < kv; i++)
        begin
            v = 8'($urandom);
            sum += v;
            plan_byte(v);
        end
        plan_byte(serial);
        plan_byte(corrupt ? (sum ^ (8'h01 << $urandom_range(7))) : sum);
    endtask

    // key frame with an illegal length byte; lengths past the buffer run it into overflow
    task automatic plan_bad_key(input int len);
        int i;
        plan_byte(HDR_BYTE0);
        plan_byte(HDR_BYTE1);
        plan_byte($urandom_range(1) ? T_KEY_A : T_KEY_B);
        plan_byte(8'(len));
        for (i = 0; i < ((len > BUF_BYTES - 3) ? BUF_BYTES - 3 : len); i++)
            plan_byte(8'($urandom));
    endtask

    function automatic int idle_pct(idle_mode_t m, bit receiver);
        case (m)
            SLOW_READER: return receiver ? 83 : 15;
            SLOW_WRITER: return receiver ? 15 : 83;
            default:     return 0;
        endcase
    endfunction

    function automatic string word_text(hid_result_t w);
        return $sformatf({"ev=%0d type=%0d status=%02h port=%0d proto=%0d kind=%0d",
                          " serial=%02h check=%02h data=%02h count=%0d last=%0d"},
                         w.event_res, w.msg_type, w.status_byte, w.port, w.protocol,
                         w.kind, w.serial_number, w.check_byte, w.data_byte,
                         w.data_count, w.last);
    endfunction

    // ------------------------------------------------------------------
    // driver: presents the next planned byte, model runs on each accepted word
    // ------------------------------------------------------------------
    idle_mode_t live_mode = SLOW_READER;
    int         bytes_accepted = 0;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rx_valid <= 1'b0;
            rx_byte  <= 8'h00;
        end
        else
        begin
            if (rx_valid && rx_ready)
            begin
                decode_rx_byte(rx_byte);
                bytes_accepted++;
            end
            // channel free: either offer the next word or idle this cycle
            if (!rx_valid || rx_ready)
            begin
                if (rx_plan.size() != 0
                    && !(rx_plan[0].hold_for_drain && pending_results.size() != 0)
                    && $urandom_range(99) >= idle_pct(rx_plan[0].mode, 1'b0))
                begin
                    rx_valid  <= 1'b1;
                    rx_byte   <= rx_plan[0].value;
                    live_mode <= rx_plan[0].mode;
                    void'(rx_plan.pop_front());
                end
                else
                begin
                    rx_valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // monitor: random back-pressure, checks each accepted result word in order
    // ------------------------------------------------------------------
    hid_result_t seen_word;
    hid_result_t want_word;
    int          mismatch_count = 0;
    int          results_seen = 0;
    int          ev_tally [8] = '{default: 0};

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_ready <= 1'b0;
        end
        else
        begin
            if (res_valid && res_ready)
            begin
                seen_word = {event_res, msg_type, status_byte, port, protocol, kind,
                             serial_number, check_byte, data_byte, data_count, last};
                results_seen++;
                ev_tally[seen_word.event_res]++;
                if (pending_results.size() == 0)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("unexpected result word %0d: %s", results_seen,
                                 word_text(seen_word));
                end
                else
                begin
                    want_word = pending_results.pop_front();
                    if (seen_word !== want_word)
                    begin
                        mismatch_count++;
                        if (mismatch_count <= 10)
                        begin
                            $display("result word %0d differs", results_seen);
                            $display("  expected %s", word_text(want_word));
                            $display("  actual   %s", word_text(seen_word));
                        end
                    end
                end
            end
            res_ready <= ($urandom_range(99) >= idle_pct(live_mode, 1'b1));
        end
    end

    // run limit
    int cycle_count = 0;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT_CYCLES)
        begin
            $display("run limit of %0d cycles reached, %0d results still pending",
                     LIMIT_CYCLES, pending_results.size());
            $display("Mismatches found");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // stimulus plan, reset and end of run
    // ------------------------------------------------------------------
    initial
    begin
        int         planned_bytes;
        int         pick;
        int         n;
        int         target;
        logic [7:0] v;

        // directed: every frame type once, byte extremes, leading noise
        plan_byte(8'hFF);
        plan_byte(HDR_BYTE0); plan_byte(HDR_BYTE1); plan_byte(T_STAT_REQ); plan_byte(8'hFF);
        plan_byte(HDR_BYTE0); plan_byte(HDR_BYTE1); plan_byte(T_RESET);
        plan_byte(HDR_BYTE0); plan_byte(HDR_BYTE1); plan_byte(T_STAT1); plan_byte(8'h00);
        plan_byte(HDR_BYTE0); plan_byte(HDR_BYTE1); plan_byte(T_DISCONNECT);
        plan_byte(HDR_BYTE0); plan_byte(HDR_BYTE1); plan_byte(T_VERSION);
        plan_byte(HDR_BYTE0); plan_byte(HDR_BYTE1); plan_byte(T_STAT2); plan_byte(8'hFF);
        plan_byte(HDR_BYTE0); plan_byte(HDR_BYTE1); plan_byte(T_STAT); plan_byte(8'h5A);
        plan_key_frame(0, 1'b0);

        // random: mostly well-formed frames with random content, some broken ones
        for (int m = SLOW_READER; m <= NO_IDLE; m++)
        begin
            plan_mode = idle_mode_t'(m);
            // sender holds off at each mode change until all results are back
            plan_hold = (m != SLOW_READER);
            if (plan_mode == SLOW_WRITER)
                plan_bad_key($urandom_range(BUF_BYTES - 3, 255));
            target = (m + 1) * PHASE_BYTES;
            while (rx_plan.size() < target)
            begin
                pick = $urandom_range(99);
                if (pick < 40)
                begin
                    n = $urandom_range(99);
                    n = (n < 70) ? $urandom_range(4) :
                        (n < 95) ? $urandom_range(KEY_MAX - 1, 5) : KEY_MAX;
                    plan_key_frame(n, 1'b0);
                end
                else if (pick < 45)
                    plan_key_frame($urandom_range(8), 1'b1);
                else if (pick < 49)
                begin
                    n = $urandom_range(3);
                    plan_bad_key((n == 0) ? $urandom_range(2) :
                                 (n == 3) ? $urandom_range(255, BUF_BYTES - 3) :
                                            $urandom_range(BUF_BYTES - 4, KEY_MAX + 4));
                end
                else if (pick < 65)
                begin
                    n = $urandom_range(2);
                    plan_byte(HDR_BYTE0);
                    plan_byte(HDR_BYTE1);
                    plan_byte((n == 0) ? T_STAT1 : (n == 1) ? T_STAT2 : T_STAT);
                    plan_byte(8'($urandom));
                end
                else if (pick < 72)
                begin
                    // status request, half of them with the mask forced on, the rest random and often broken
                    v = 8'($urandom);
                    if ($urandom_range(1))
                        v = v | STAT_REQ_MASK;
                    plan_byte(HDR_BYTE0);
                    plan_byte(HDR_BYTE1);
                    plan_byte(T_STAT_REQ);
                    plan_byte(v);
                end
                else if (pick < 82)
                begin
                    n = $urandom_range(2);
                    plan_byte(HDR_BYTE0);
                    plan_byte(HDR_BYTE1);
                    plan_byte((n == 0) ? T_RESET : (n == 1) ? T_DISCONNECT : T_VERSION);
                end
                else if (pick < 92)
                begin
                    for (n = $urandom_range(3, 1); n > 0; n--)
                        plan_byte($urandom_range(3) == 0 ? HDR_BYTE0 : 8'($urandom));
                end
                else
                begin
                    // truncated or mistyped header
                    plan_byte(HDR_BYTE0);
                    if ($urandom_range(1))
                    begin
                        plan_byte(HDR_BYTE1);
                        plan_byte(8'($urandom));
                    end
                end
            end
        end
        planned_bytes = rx_plan.size();

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        wait (bytes_accepted == planned_bytes);
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("sent %0d bytes in three idle modes, checked %0d result words", planned_bytes,
                 results_seen);
        $display("good words %0d, overflow flushes %0d, key length errors %0d, checksum errors %0d",
                 ev_tally[EV_OK], ev_tally[EV_OVERFLOW], ev_tally[EV_KEY_LEN],
                 ev_tally[EV_CHECKSUM]);
        if (mismatch_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

// File: hid_uart_frame_parser.f
hdl/hufp_pkg.sv
hdl/hufp_ram.sv
hdl/hufp_datapath.sv
hdl/hufp_ctrl.sv
hdl/hid_uart_frame_parser.sv
tb/testbench.sv
